// ----- rtl/trd_pkg.sv -----
`timescale 1ns / 1ps
// trd_pkg: shared types and constants of the touch report decoder
// no dependencies; imported by trd_scaler and touch_report_decoder_core

package trd_pkg;

	// field widths fixed by the record and result formats
	localparam int RAW_W      = 12;
	localparam int PANEL_W    = 16;
	localparam int X_W        = 9;
	localparam int Y_W        = 8;
	localparam int SLOT_CNT_W = 4;
	localparam int CFG_IDX_W  = 4;

	// screen size that the result widths are built for
	localparam int SCREEN_W = 320;
	localparam int SCREEN_H = 240;

	// operation codes of an input request
	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_READ   = 1'b1;

	// event code that opens a touch
	localparam logic [2:0] EVT_START = 3'd1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PANEL_W = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PANEL_H = 4'd1;

	// configuration reset values
	localparam logic [PANEL_W-1:0] PANEL_W_RST = 16'd448;
	localparam logic [PANEL_W-1:0] PANEL_H_RST = 16'd320;

	typedef struct packed {
		logic       op;
		logic [7:0] id_event_byte;
		logic [7:0] x_high_byte;
		logic [7:0] y_high_byte;
		logic [7:0] xy_low_byte;
	} in_t;

	typedef struct packed {
		logic           touch_valid;
		logic [X_W-1:0] x_pos;
		logic [Y_W-1:0] y_pos;
		logic           missed;
	} out_t;

	typedef enum logic [1:0] {
		SC_IDLE,
		SC_MUL,
		SC_DIV
	} scl_state_t;

	typedef enum logic {
		TS_IDLE,
		TS_WAIT
	} trd_state_t;

endpackage

// ----- rtl/trd_scaler.sv -----
`timescale 1ns / 1ps
// trd_scaler: bit-serial scaling of one raw coordinate, raw * SCREEN / panel, saturated
// shift-add multiply then restoring divide; depends on trd_pkg

module trd_scaler #(
	parameter int SCREEN = 320
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [trd_pkg::RAW_W-1:0]   raw,
	input  logic [trd_pkg::PANEL_W-1:0] panel,
	output logic                        busy,
	output logic [$clog2(SCREEN)-1:0]   quo
);
	import trd_pkg::*;

	localparam int SCR_W = $clog2(SCREEN + 1);
	localparam int PW    = RAW_W + SCR_W;
	localparam int QW    = $clog2(SCREEN);
	localparam int CW    = $clog2((RAW_W > QW) ? RAW_W : QW);

	scl_state_t        state_q, state_d;
	logic [CW-1:0]     cnt_q;
	logic [RAW_W-1:0]  raw_q;
	logic [PW-1:0]     acc_q;
	logic [PW-1:0]     acc_next;
	logic [PANEL_W-1:0] panel_q;
	logic [PANEL_W-1:0] rem_q;
	logic [QW-1:0]     quo_q;
	logic [PANEL_W:0]  trial;
	logic              ge;
	logic              sat;
	logic              mul_en;
	logic              div_en;
	logic              mul_last;
	logic              div_last;

	// a quotient at or past the screen edge happens exactly when raw >= panel
	assign sat = {{(PANEL_W-RAW_W){1'b0}}, raw} >= panel;

	// one multiply step: msb of raw first
	assign acc_next = (acc_q << 1) + (raw_q[RAW_W-1] ? PW'(SCREEN) : '0);

	// one restoring divide step
	assign trial = {rem_q, acc_q[QW-1]};
	assign ge    = trial >= {1'b0, panel_q};

	assign mul_last = cnt_q == CW'(RAW_W - 1);
	assign div_last = cnt_q == CW'(QW - 1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			SC_IDLE: begin
				if (start && !sat) state_d = SC_MUL;
			end
			SC_MUL: begin
				if (mul_last) state_d = SC_DIV;
			end
			SC_DIV: begin
				if (div_last) state_d = SC_IDLE;
			end
			default: state_d = SC_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		busy   = 1'b0;
		mul_en = 1'b0;
		div_en = 1'b0;
		case (state_q)
			SC_IDLE: ;
			SC_MUL: begin
				busy   = 1'b1;
				mul_en = 1'b1;
			end
			SC_DIV: begin
				busy   = 1'b1;
				div_en = 1'b1;
			end
			default: busy = 1'b0;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SC_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (start || (mul_en && mul_last) || (div_en && div_last)) begin
				cnt_q <= '0;
			end else if (mul_en || div_en) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// datapath shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			raw_q   <= raw;
			panel_q <= panel;
			acc_q   <= '0;
			if (sat) quo_q <= QW'(SCREEN - 1);
		end else if (mul_en) begin
			raw_q <= raw_q << 1;
			acc_q <= acc_next;
			// quotient stays below 2^QW, so the top bits already sit below panel
			if (mul_last) rem_q <= PANEL_W'(acc_next >> QW);
		end else if (div_en) begin
			acc_q <= acc_q << 1;
			rem_q <= ge ? PANEL_W'(trial - {1'b0, panel_q}) : trial[PANEL_W-1:0];
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign quo = quo_q;

	// remainder stays below the divisor while dividing
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == SC_DIV |-> rem_q < panel_q)
		else $error("scaler remainder not below panel");

	// a saturating start finishes at once with the edge pixel
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && sat) |=> (!busy && quo_q == QW'(SCREEN - 1)))
		else $error("scaler saturation result wrong");

	// multiply phase always hands over to the divide phase
	a_mul_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SC_MUL && mul_last) |=> state_q == SC_DIV)
		else $error("scaler skipped divide phase");

endmodule

// ----- rtl/touch_report_decoder_core.sv -----
`timescale 1ns / 1ps
// touch_report_decoder_core: decodes finger records into stored finger positions
// and answers host reads of finger 0; depends on trd_pkg and trd_scaler
//
// a record without a start event is handled when it is accepted; a start record stalls
// the input until the bit-serial multiply (12 steps) and restoring divide of the two
// parallel scalers finish, which are skipped when both coordinates saturate
// a host read has its result registered on the output
// reset clears all flags, slot count and presence bits, panel size to 448x320

module touch_report_decoder_core #(
	parameter int FINGERS  = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  trd_pkg::in_t                  in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output trd_pkg::out_t                 out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [trd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [trd_pkg::PANEL_W-1:0]   cfg_data
);
	import trd_pkg::*;

	localparam int SLOT_W = (FINGERS > 1) ? $clog2(FINGERS) : 1;
	localparam int QX_W   = $clog2(SCREEN_W);
	localparam int QY_W   = $clog2(SCREEN_H);

	trd_state_t          state_q, state_d;
	logic [PANEL_W-1:0]  panel_w_q;
	logic [PANEL_W-1:0]  panel_h_q;
	logic [SLOT_CNT_W-1:0] slot_cnt_q;
	logic [SLOT_CNT_W-1:0] slot_q;
	logic [SLOT_CNT_W-1:0] slot_in;
	logic [SLOT_CNT_W-1:0] slot_sel;
	logic                finger_present_q [FINGERS];
	logic [X_W-1:0]      finger_x_q [FINGERS];
	logic [Y_W-1:0]      finger_y_q [FINGERS];
	logic                new_touch_q;
	logic                data_ready_q;
	logic                data_missed_q;
	logic                out_valid_q;
	out_t                out_data_q;

	logic                in_acc;
	logic                rec_acc;
	logic                read_acc;
	logic [7:0]          track;
	logic                match;
	logic                scale_go;
	logic                commit;
	logic                advance;
	logic                last_sel;
	logic                report_end;
	logic                end_touch;
	logic                busy_x;
	logic                busy_y;
	logic [QX_W-1:0]     quo_x;
	logic [QY_W-1:0]     quo_y;
	logic [31:0]         quo_x_ext;
	logic [31:0]         quo_y_ext;
	logic [RAW_W-1:0]    raw_x;
	logic [RAW_W-1:0]    raw_y;
	logic                read_valid;

	assign cfg_ready = 1'b1;

	// record decode
	assign in_acc   = in_valid && !in_stall;
	assign rec_acc  = in_acc && in_data.op == OP_RECORD;
	assign read_acc = in_acc && in_data.op == OP_READ;
	assign slot_in  = (slot_cnt_q >= SLOT_CNT_W'(FINGERS)) ? SLOT_CNT_W'(FINGERS - 1) : slot_cnt_q;
	assign track    = {3'b000, in_data.id_event_byte[7:3]} - 8'd1;
	assign match    = track == {{(8-SLOT_CNT_W){1'b0}}, slot_in};
	assign raw_x    = {in_data.x_high_byte, in_data.xy_low_byte[7:4]};
	assign raw_y    = {in_data.y_high_byte, in_data.xy_low_byte[3:0]};

	// scalers done once both are idle in the wait state
	assign commit = state_q == TS_WAIT && !busy_x && !busy_y;

	// slot bookkeeping happens at accept for plain records, at commit for start records
	assign advance    = (rec_acc && !scale_go) || commit;
	assign slot_sel   = commit ? slot_q : slot_in;
	assign last_sel   = slot_sel == SLOT_CNT_W'(FINGERS - 1);
	assign report_end = advance && last_sel;
	assign end_touch  = commit || new_touch_q;

	assign read_valid = data_ready_q && finger_present_q[0];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			TS_IDLE: begin
				if (scale_go) state_d = TS_WAIT;
			end
			TS_WAIT: begin
				if (commit) state_d = TS_IDLE;
			end
			default: state_d = TS_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_stall = 1'b1;
		scale_go = 1'b0;
		case (state_q)
			TS_IDLE: begin
				in_stall = out_valid_q && out_stall;
				scale_go = in_valid && !in_stall && in_data.op == OP_RECORD && match
					&& in_data.id_event_byte[2:0] == EVT_START;
			end
			TS_WAIT: in_stall = 1'b1;
			default: in_stall = 1'b1;
		endcase
	end

	trd_scaler #(.SCREEN(SCREEN_W)) u_scale_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scale_go),
		.raw    (raw_x),
		.panel  (panel_w_q),
		.busy   (busy_x),
		.quo    (quo_x)
	);

	trd_scaler #(.SCREEN(SCREEN_H)) u_scale_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scale_go),
		.raw    (raw_y),
		.panel  (panel_h_q),
		.busy   (busy_y),
		.quo    (quo_y)
	);

	assign quo_x_ext = 32'(quo_x);
	assign quo_y_ext = 32'(quo_y);

	// control state and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= TS_IDLE;
			panel_w_q     <= PANEL_W_RST;
			panel_h_q     <= PANEL_H_RST;
			slot_cnt_q    <= '0;
			new_touch_q   <= 1'b0;
			data_ready_q  <= 1'b0;
			data_missed_q <= 1'b0;
			out_valid_q   <= 1'b0;
			for (int i = 0; i < FINGERS; i++) finger_present_q[i] <= 1'b0;
		end else begin
			state_q <= state_d;

			// configuration writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_PANEL_W: panel_w_q <= cfg_data;
					CFG_PANEL_H: panel_h_q <= cfg_data;
					default: ;
				endcase
			end

			// output register drain and load
			if (read_acc) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			// slot presence
			if (rec_acc && !match) finger_present_q[slot_in[SLOT_W-1:0]] <= 1'b0;
			if (commit) finger_present_q[slot_q[SLOT_W-1:0]] <= 1'b1;

			// report boundary
			if (advance) begin
				if (last_sel) slot_cnt_q <= '0;
				else slot_cnt_q <= slot_sel + 1'b1;
			end
			if (report_end) begin
				new_touch_q <= 1'b0;
			end else if (commit) begin
				new_touch_q <= 1'b1;
			end

			// ready and missed flags
			if (report_end && end_touch) begin
				data_ready_q <= 1'b1;
				if (data_ready_q) data_missed_q <= 1'b1;
			end else if (read_acc && read_valid) begin
				data_ready_q  <= 1'b0;
				data_missed_q <= 1'b0;
			end
		end
	end

	// finger positions and output payload
	always_ff @(posedge clk) begin
		if (rec_acc) slot_q <= slot_in;
		if (commit) begin
			finger_x_q[slot_q[SLOT_W-1:0]] <= quo_x_ext[X_W-1:0];
			finger_y_q[slot_q[SLOT_W-1:0]] <= quo_y_ext[Y_W-1:0];
		end
		if (read_acc) begin
			out_data_q.touch_valid <= read_valid;
			out_data_q.x_pos       <= read_valid ? finger_x_q[0] : '0;
			out_data_q.y_pos       <= read_valid ? finger_y_q[0] : '0;
			out_data_q.missed      <= data_missed_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// missed is only ever raised on top of ready
	a_missed_ready: assert property (@(posedge clk) disable iff (!arst_n)
		data_missed_q |-> data_ready_q)
		else $error("missed flag set without ready");

	// slot counter stays inside the finger range
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_cnt_q < SLOT_CNT_W'(FINGERS))
		else $error("slot counter out of range");

	// a start record returns to idle once both scalers finish
	a_commit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> state_q == TS_IDLE)
		else $error("decoder stuck after scaling");

	// an accepted read always presents a result next cycle
	a_read_out: assert property (@(posedge clk) disable iff (!arst_n)
		read_acc |=> out_valid_q)
		else $error("host read lost its result");

endmodule
